[hdl/rounded_rect_alpha_premultiply_defines.svh]
// Assertion macros for the rounded-rect alpha premultiply checker.
// Included by the checker file only; no other dependencies.
`ifndef ROUNDED_RECT_ALPHA_PREMULTIPLY_DEFINES_SVH
`define ROUNDED_RECT_ALPHA_PREMULTIPLY_DEFINES_SVH

// Check cons in the same cycle whenever ante holds.
`define RRAP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds.
`define RRAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/rrap_pkg.sv]
// Shared constants, register codes and pipeline types for the rounded-rect
// alpha premultiply block. No dependencies.
`default_nettype none

package rrap_pkg;

   // Field widths
   localparam int COORD_BITS  = 11;
   localparam int FRAC_BITS   = 8;
   localparam int RADIUS_BITS = 8;
   localparam int COLOR_BITS  = 8;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_ADDR_BITS  = CSR_INDEX_BITS + 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CARD_WIDTH    = 2'd0,
      CSR_CARD_HEIGHT   = 2'd1,
      CSR_CORNER_RADIUS = 2'd2
   } csr_index_type;

   localparam logic [COORD_BITS-1:0]  CARD_WIDTH_RESET    = COORD_BITS'(340);
   localparam logic [COORD_BITS-1:0]  CARD_HEIGHT_RESET   = COORD_BITS'(360);
   localparam logic [RADIUS_BITS-1:0] CORNER_RADIUS_RESET = RADIUS_BITS'(8);

   // Fixed-point lengths: signed distance, clamped corner offset, root
   localparam int DIST_BITS = COORD_BITS + FRAC_BITS + 2;
   localparam int LIM_BITS  = RADIUS_BITS + FRAC_BITS + 1;
   localparam int SQ_BITS   = 2 * LIM_BITS;
   localparam int ROOT_BITS = LIM_BITS + 1;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;

   // Square root pipeline: two digits per stage
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES =
      (ROOT_BITS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;

   // Truncating divide by 255 of an 8x8 product: multiply and shift
   localparam int PROD_BITS  = 2 * COLOR_BITS;
   localparam int RECIP_BITS = 16;
   localparam logic [RECIP_BITS-1:0] DIV255_RECIP = 16'h8081;
   localparam int DIV255_SHIFT = 23;

   typedef struct packed {
      logic [COORD_BITS-1:0]  card_width;
      logic [COORD_BITS-1:0]  card_height;
      logic [RADIUS_BITS-1:0] corner_radius;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      card_width:    CARD_WIDTH_RESET,
      card_height:   CARD_HEIGHT_RESET,
      corner_radius: CORNER_RADIUS_RESET
   };

   typedef struct packed {
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } color_type;

   // Data that rides along the distance and root stages
   typedef struct packed {
      color_type                    color;
      logic                         corner;
      logic signed [DIST_BITS-1:0]  dmax;
   } side_type;

   typedef struct packed {
      logic [RAD_BITS-1:0] rad;
      side_type            side;
   } geom_type;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      side_type             side;
   } sq_state_type;

endpackage

`default_nettype wire

[hdl/rrap_req_if.sv]
// Pixel request channel: valid/ready handshake with coordinates and color.
// Depends on rrap_pkg.
`default_nettype none

interface rrap_req_if;
   import rrap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_column;
   logic [COORD_BITS-1:0] pixel_row;
   logic [COLOR_BITS-1:0] in_blue;
   logic [COLOR_BITS-1:0] in_green;
   logic [COLOR_BITS-1:0] in_red;

   modport source (
      output valid, pixel_column, pixel_row, in_blue, in_green, in_red,
      input  ready
   );

   modport sink (
      input  valid, pixel_column, pixel_row, in_blue, in_green, in_red,
      output ready
   );
endinterface

`default_nettype wire

[hdl/rrap_rsp_if.sv]
// Result channel: valid/ready handshake with premultiplied color and alpha.
// Depends on rrap_pkg.
`default_nettype none

interface rrap_rsp_if;
   import rrap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] out_blue;
   logic [COLOR_BITS-1:0] out_green;
   logic [COLOR_BITS-1:0] out_red;
   logic [COLOR_BITS-1:0] out_alpha;

   modport source (
      output valid, out_blue, out_green, out_red, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, out_blue, out_green, out_red, out_alpha,
      output ready
   );
endinterface

`default_nettype wire

[hdl/rounded_rect_alpha_premultiply.sv]
// Rounded-rectangle alpha mask with color premultiply (top level).
// Depends on rrap_pkg, rrap_req_if, rrap_rsp_if, rrap_csr, rrap_dist,
// rrap_sqrt and rrap_blend.
//
// req_ch takes one pixel per item: column, row and three color bytes.
// rsp_ch returns one item per pixel: the colors times alpha / 255 and alpha,
// in request order. Both channels use valid/ready.
// The csr_ port holds card width, card height and corner radius; write it
// only while no item is in flight.
// From request accept to result valid an item passes 4 distance stages,
// 9 square-root stages at two root bits each and 4 blend stages.
// Throughput is one item per cycle while rsp_ch is ready; every stage holds one item.
// A stalled rsp_ch holds the result; the pipeline keeps filling its empty
// stages and drops req_ch.ready only once every stage is full.
// Synchronous reset empties the pipeline and restores the register defaults
// (width 340, height 360, radius 8).
`default_nettype none

module rounded_rect_alpha_premultiply (
   input  logic                               clock,
   input  logic                               reset,
   rrap_req_if.sink                           req_ch,
   rrap_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rrap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import rrap_pkg::*;

   cfg_type      cfg;
   color_type    req_color;
   color_type    rsp_color;
   logic         geom_valid;
   logic         geom_ready;
   geom_type     geom;
   logic         root_valid;
   logic         root_ready;
   sq_state_type root_state;

   rrap_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gather the request color bytes
   assign req_color.blue  = req_ch.in_blue;
   assign req_color.green = req_ch.in_green;
   assign req_color.red   = req_ch.in_red;

   rrap_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_column (req_ch.pixel_column),
      .in_row    (req_ch.pixel_row),
      .in_color  (req_color),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_geom  (geom)
   );

   rrap_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_geom   (geom),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_state (root_state)
   );

   rrap_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .corner_radius (cfg.corner_radius),
      .in_valid      (root_valid),
      .in_ready      (root_ready),
      .in_state      (root_state),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_color     (rsp_color),
      .out_alpha     (rsp_ch.out_alpha)
   );

   // Spread the result color bytes
   assign rsp_ch.out_blue  = rsp_color.blue;
   assign rsp_ch.out_green = rsp_color.green;
   assign rsp_ch.out_red   = rsp_color.red;

endmodule

`default_nettype wire

[hdl/rrap_csr.sv]
// APB-style register file for card width, card height and corner radius.
// Depends on rrap_pkg.
`default_nettype none

module rrap_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rrap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output rrap_pkg::cfg_type                  cfg
);
   import rrap_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Update the addressed register on the access cycle
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_CARD_WIDTH:    cfg_in.card_width    = csr_pwdata[COORD_BITS-1:0];
            CSR_CARD_HEIGHT:   cfg_in.card_height   = csr_pwdata[COORD_BITS-1:0];
            CSR_CORNER_RADIUS: cfg_in.corner_radius = csr_pwdata[RADIUS_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         CSR_CARD_WIDTH:    csr_prdata = CSR_DATA_BITS'(cfg_ff.card_width);
         CSR_CARD_HEIGHT:   csr_prdata = CSR_DATA_BITS'(cfg_ff.card_height);
         CSR_CORNER_RADIUS: csr_prdata = CSR_DATA_BITS'(cfg_ff.corner_radius);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[hdl/rrap_dist.sv]
// Four-stage front end: axis distances, corner clamp, squares, radicand sum.
// Depends on rrap_pkg.
`default_nettype none

module rrap_dist (
   input  logic                            clock,
   input  logic                            reset,
   input  rrap_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [rrap_pkg::COORD_BITS-1:0] in_column,
   input  logic [rrap_pkg::COORD_BITS-1:0] in_row,
   input  rrap_pkg::color_type             in_color,
   output logic                            out_valid,
   input  logic                            out_ready,
   output rrap_pkg::geom_type              out_geom
);
   import rrap_pkg::*;

   localparam int STAGES    = 4;
   localparam int HALF_PAD  = DIST_BITS - COORD_BITS - FRAC_BITS + 1;
   localparam int RAD_PAD   = DIST_BITS - RADIUS_BITS - FRAC_BITS;
   localparam int POS_PAD   = DIST_BITS - COORD_BITS - FRAC_BITS;
   localparam logic [LIM_BITS-1:0] TWO_PX = LIM_BITS'(2 << FRAC_BITS);

   // |pos - half| - inner, all in signed fixed point
   function automatic logic signed [DIST_BITS-1:0] axis_offset(
      input logic signed [DIST_BITS-1:0] pos,
      input logic signed [DIST_BITS-1:0] half,
      input logic signed [DIST_BITS-1:0] inner
   );
      logic signed [DIST_BITS-1:0] diff;
      logic signed [DIST_BITS-1:0] mag;
      diff = pos - half;
      mag  = diff[DIST_BITS-1] ? -diff : diff;
      return mag - inner;
   endfunction

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_src;
   logic [STAGES:0]   adv;

   logic signed [DIST_BITS-1:0] half_w;
   logic signed [DIST_BITS-1:0] half_h;
   logic signed [DIST_BITS-1:0] r_fx;
   logic signed [DIST_BITS-1:0] pos_x;
   logic signed [DIST_BITS-1:0] pos_y;
   logic [LIM_BITS-1:0]         lim;
   logic signed [DIST_BITS-1:0] lim_s;

   logic signed [DIST_BITS-1:0] dx_ff, dx_in;
   logic signed [DIST_BITS-1:0] dy_ff, dy_in;
   color_type                   color1_ff;
   logic [LIM_BITS-1:0]         ax_ff, ax_in;
   logic [LIM_BITS-1:0]         ay_ff, ay_in;
   side_type                    side2_ff, side2_in;
   logic [SQ_BITS-1:0]          sqx_ff, sqx_in;
   logic [SQ_BITS-1:0]          sqy_ff, sqy_in;
   side_type                    side3_ff;
   geom_type                    geom_ff, geom_in;

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      adv[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_src = {valid_ff[STAGES-2:0], in_valid};
   assign valid_in  = (adv[STAGES-1:0] & valid_src) | (~adv[STAGES-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: pixel centre against card half extents
   assign half_w = signed'({{HALF_PAD{1'b0}}, cfg.card_width, {(FRAC_BITS-1){1'b0}}});
   assign half_h = signed'({{HALF_PAD{1'b0}}, cfg.card_height, {(FRAC_BITS-1){1'b0}}});
   assign r_fx   = signed'({{RAD_PAD{1'b0}}, cfg.corner_radius, {FRAC_BITS{1'b0}}});
   assign pos_x  = signed'({{POS_PAD{1'b0}}, in_column, 1'b1, {(FRAC_BITS-1){1'b0}}});
   assign pos_y  = signed'({{POS_PAD{1'b0}}, in_row, 1'b1, {(FRAC_BITS-1){1'b0}}});
   assign dx_in  = axis_offset(pos_x, half_w, half_w - r_fx);
   assign dy_in  = axis_offset(pos_y, half_h, half_h - r_fx);

   // Stage 2: corner test, clamp offsets to radius plus two pixels
   assign lim   = {1'b0, cfg.corner_radius, {FRAC_BITS{1'b0}}} + TWO_PX;
   assign lim_s = signed'(DIST_BITS'(lim));

   always_comb begin
      ax_in = (dx_ff > lim_s) ? lim : dx_ff[LIM_BITS-1:0];
      ay_in = (dy_ff > lim_s) ? lim : dy_ff[LIM_BITS-1:0];
      side2_in.color  = color1_ff;
      side2_in.corner = (dx_ff > 0) && (dy_ff > 0);
      side2_in.dmax   = (dx_ff > dy_ff) ? dx_ff : dy_ff;
   end

   // Stage 3: square both offsets
   assign sqx_in = ax_ff * ax_ff;
   assign sqy_in = ay_ff * ay_ff;

   // Stage 4: sum of squares
   assign geom_in.rad  = RAD_BITS'(sqx_ff) + RAD_BITS'(sqy_ff);
   assign geom_in.side = side3_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         color1_ff <= in_color;
      end
      if (adv[1]) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         side2_ff <= side2_in;
      end
      if (adv[2]) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         side3_ff <= side2_ff;
      end
      if (adv[3]) begin
         geom_ff <= geom_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_geom  = geom_ff;

endmodule

`default_nettype wire

[hdl/rrap_sqrt.sv]
// Pipelined digit-by-digit square root, two result bits per stage.
// Depends on rrap_pkg.
`default_nettype none

module rrap_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rrap_pkg::geom_type     in_geom,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rrap_pkg::sq_state_type out_state
);
   import rrap_pkg::*;

   // One restoring step: bring down two radicand bits, try root*4+1
   function automatic sq_state_type sqrt_step(input sq_state_type cur);
      sq_state_type         nxt;
      logic [REM_BITS+1:0]  rem_sh;
      logic [REM_BITS+1:0]  trial;
      nxt    = cur;
      rem_sh = {cur.rem, cur.rad[RAD_BITS-1 -: 2]};
      trial  = (REM_BITS + 2)'({cur.root, 2'b01});
      nxt.rad = cur.rad << 2;
      if (rem_sh >= trial) begin
         nxt.rem  = REM_BITS'(rem_sh - trial);
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         nxt.rem  = REM_BITS'(rem_sh);
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES-1:0] valid_in;
   logic [SQRT_STAGES-1:0] valid_src;
   logic [SQRT_STAGES:0]   adv;
   sq_state_type           init_state;
   sq_state_type           stage_src [SQRT_STAGES];
   sq_state_type           state_in  [SQRT_STAGES];
   sq_state_type           state_ff  [SQRT_STAGES];

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      adv[SQRT_STAGES] = out_ready;
      for (int i = SQRT_STAGES - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_src = {valid_ff[SQRT_STAGES-2:0], in_valid};
   assign valid_in  = (adv[SQRT_STAGES-1:0] & valid_src)
                    | (~adv[SQRT_STAGES-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Start with empty root and remainder
   always_comb begin
      init_state.rad  = in_geom.rad;
      init_state.rem  = '0;
      init_state.root = '0;
      init_state.side = in_geom.side;
   end

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign stage_src[s] = init_state;
      end else begin : g_next
         assign stage_src[s] = state_ff[s-1];
      end

      // Run this stage's share of the digit steps
      always_comb begin
         state_in[s] = stage_src[s];
         for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
            if (s * SQRT_STEPS_PER_STAGE + j < ROOT_BITS) begin
               state_in[s] = sqrt_step(state_in[s]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            state_ff[s] <= state_in[s];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_state = state_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

[hdl/rrap_blend.sv]
// Four-stage back end: rounded distance, coverage to alpha, color product,
// divide by 255. Depends on rrap_pkg.
`default_nettype none

module rrap_blend (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rrap_pkg::RADIUS_BITS-1:0] corner_radius,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  rrap_pkg::sq_state_type           in_state,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rrap_pkg::color_type              out_color,
   output logic [rrap_pkg::COLOR_BITS-1:0]  out_alpha
);
   import rrap_pkg::*;

   localparam int STAGES      = 4;
   localparam int D_BITS      = DIST_BITS + 1;
   localparam int COV_BITS    = FRAC_BITS + 1;
   localparam int SCALED_BITS = FRAC_BITS + COLOR_BITS + 1;
   localparam int QUOT_BITS   = PROD_BITS + RECIP_BITS;
   localparam logic signed [D_BITS-1:0] HALF_D     = D_BITS'(1 << (FRAC_BITS - 1));
   localparam logic signed [D_BITS-1:0] NEG_HALF_D = -HALF_D;
   localparam logic [COV_BITS-1:0]      ONE_COV    = COV_BITS'(1 << FRAC_BITS);
   localparam logic [SCALED_BITS-1:0]   HALF_SC    = SCALED_BITS'(1 << (FRAC_BITS - 1));

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_src;
   logic [STAGES:0]   adv;

   logic                     round_up;
   logic [ROOT_BITS:0]       root_rnd;
   logic signed [D_BITS-1:0] r_fx;
   logic [COV_BITS-1:0]      cov;
   logic [SCALED_BITS-1:0]   scaled;
   logic [QUOT_BITS-1:0]     quot_b;
   logic [QUOT_BITS-1:0]     quot_g;
   logic [QUOT_BITS-1:0]     quot_r;

   logic signed [D_BITS-1:0] dist_ff, dist_in;
   color_type                color1_ff;
   logic [COLOR_BITS-1:0]    alpha2_ff, alpha2_in;
   color_type                color2_ff;
   logic [PROD_BITS-1:0]     prod_b_ff, prod_g_ff, prod_r_ff;
   logic [COLOR_BITS-1:0]    alpha3_ff;
   color_type                color4_ff, color4_in;
   logic [COLOR_BITS-1:0]    alpha4_ff;

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      adv[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_src = {valid_ff[STAGES-2:0], in_valid};
   assign valid_in  = (adv[STAGES-1:0] & valid_src) | (~adv[STAGES-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: round the root to nearest and subtract the radius; outside a corner use the larger axis offset
   assign r_fx     = signed'(D_BITS'({corner_radius, {FRAC_BITS{1'b0}}}));
   assign round_up = in_state.rem > REM_BITS'(in_state.root);
   assign root_rnd = (ROOT_BITS + 1)'(in_state.root) + (ROOT_BITS + 1)'(round_up);

   always_comb begin
      if (in_state.side.corner) begin
         dist_in = signed'(D_BITS'(root_rnd)) - r_fx;
      end else begin
         dist_in = D_BITS'(in_state.side.dmax) - r_fx;
      end
   end

   // Stage 2: coverage = 1/2 - d clamped to 0..1, scaled to a rounded byte
   always_comb begin
      priority if (dist_ff > HALF_D) begin
         cov = '0;
      end else if (dist_ff < NEG_HALF_D) begin
         cov = ONE_COV;
      end else begin
         cov = COV_BITS'(HALF_D - dist_ff);
      end
      scaled    = {cov, {COLOR_BITS{1'b0}}} - SCALED_BITS'(cov) + HALF_SC;
      alpha2_in = scaled[FRAC_BITS +: COLOR_BITS];
   end

   // Stage 4: divide each product by 255, truncating
   assign quot_b = prod_b_ff * DIV255_RECIP;
   assign quot_g = prod_g_ff * DIV255_RECIP;
   assign quot_r = prod_r_ff * DIV255_RECIP;
   assign color4_in.blue  = quot_b[DIV255_SHIFT +: COLOR_BITS];
   assign color4_in.green = quot_g[DIV255_SHIFT +: COLOR_BITS];
   assign color4_in.red   = quot_r[DIV255_SHIFT +: COLOR_BITS];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dist_ff   <= dist_in;
         color1_ff <= in_state.side.color;
      end
      if (adv[1]) begin
         alpha2_ff <= alpha2_in;
         color2_ff <= color1_ff;
      end
      // Stage 3: premultiply each color byte
      if (adv[2]) begin
         prod_b_ff <= color2_ff.blue * alpha2_ff;
         prod_g_ff <= color2_ff.green * alpha2_ff;
         prod_r_ff <= color2_ff.red * alpha2_ff;
         alpha3_ff <= alpha2_ff;
      end
      if (adv[3]) begin
         color4_ff <= color4_in;
         alpha4_ff <= alpha3_ff;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_color = color4_ff;
   assign out_alpha = alpha4_ff;

endmodule

`default_nettype wire

[hdl/rrap_checker.sv]
// Port-level checker for rounded_rect_alpha_premultiply, bound to the top.
// Depends on rrap_pkg and rounded_rect_alpha_premultiply_defines.svh.
`default_nettype none
`include "rounded_rect_alpha_premultiply_defines.svh"

module rrap_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rrap_pkg::COLOR_BITS-1:0]    out_blue,
   input logic [rrap_pkg::COLOR_BITS-1:0]    out_green,
   input logic [rrap_pkg::COLOR_BITS-1:0]    out_red,
   input logic [rrap_pkg::COLOR_BITS-1:0]    out_alpha,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [rrap_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [rrap_pkg::CSR_DATA_BITS-1:0] csr_prdata
);
   import rrap_pkg::*;

   logic                        rsp_stall;
   logic [4*COLOR_BITS-1:0]     rsp_word;
   logic                        colors_bounded;
   logic                        csr_wr;
   logic                        width_sel;
   logic                        width_rd;
   logic                        width_wr_d1_ff;
   logic                        width_wr_d2_ff;
   logic [COORD_BITS-1:0]       wdata_d1_ff;
   logic [COORD_BITS-1:0]       wdata_d2_ff;
   logic                        wb_check;
   logic [CSR_DATA_BITS-1:0]    wb_expect;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_word       = {out_blue, out_green, out_red, out_alpha};
   assign colors_bounded = (out_blue <= out_alpha) && (out_green <= out_alpha)
                        && (out_red <= out_alpha);

   // Track a width write, then no write, then a width read
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign width_sel = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]) == CSR_CARD_WIDTH;
   assign width_rd  = csr_psel && csr_penable && !csr_pwrite && width_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_wr_d1_ff <= 1'b0;
         width_wr_d2_ff <= 1'b0;
      end else begin
         width_wr_d1_ff <= csr_wr && width_sel;
         width_wr_d2_ff <= width_wr_d1_ff && !csr_wr;
      end
   end

   always_ff @(posedge clock) begin
      wdata_d1_ff <= csr_pwdata[COORD_BITS-1:0];
      wdata_d2_ff <= wdata_d1_ff;
   end

   assign wb_check  = width_wr_d2_ff && width_rd;
   assign wb_expect = CSR_DATA_BITS'(wdata_d2_ff);

   `RRAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word), "result item changed while stalled")
   `RRAP_ASSERT_IMP(a_color_bound, clock, reset, rsp_valid, colors_bounded, "premultiplied color exceeds alpha")
   `RRAP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")
   `RRAP_ASSERT_IMP(a_width_readback, clock, reset, wb_check, csr_prdata == wb_expect, "card width read back wrong")

endmodule

bind rounded_rect_alpha_premultiply rrap_checker u_rrap_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_blue    (rsp_ch.out_blue),
   .out_green   (rsp_ch.out_green),
   .out_red     (rsp_ch.out_red),
   .out_alpha   (rsp_ch.out_alpha),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire
